// ===== rtl/core/bpm_pkg.sv =====
// ----------------------------------------------------------------------------
// bpm_pkg
// shared constants for the bipartite matching block
// ----------------------------------------------------------------------------
package bpm_pkg;
  localparam int MaxLeft  = 64;
  localparam int MaxRight = 64;
  localparam int LW = $clog2(MaxLeft);
  localparam int RW = $clog2(MaxRight);
  localparam int CW = 7;

  // register select, taken from paddr[2]
  localparam logic RegLeftCount  = 1'b0;
  localparam logic RegRightCount = 1'b1;
endpackage

// ===== rtl/core/bpm_ram.sv =====
// ----------------------------------------------------------------------------
// bpm_ram
// generic single-write ram with one registered read port
// ----------------------------------------------------------------------------
module bpm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/bipartite_max_matching.sv =====
// ----------------------------------------------------------------------------
// bipartite_max_matching
// edge loader and augmenting-path maximum matching over an adjacency ram
// ----------------------------------------------------------------------------
// edge transaction: its row is read on acceptance and written back the next cycle
// with s_tready low
// finish: partner ram clear, then per left vertex a depth-first walk at one right
// vertex per cycle while no candidate is found, with a frame read on each entry or
// resume and one partner write per augment step, then an adjacency clear
// synchronous reset zeroes the counts, drops m_tvalid and runs the adjacency clear
module bipartite_max_matching (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // mode[0], left_vertex[6:1], right_vertex[12:7]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // match_count[6:0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int LW = bpm_pkg::LW;
  localparam int RW = bpm_pkg::RW;
  localparam int CW = bpm_pkg::CW;
  localparam int RowW = bpm_pkg::MaxRight;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_EDGE, S_INIT, S_NEXTU, S_FRAME, S_SCAN, S_CHECK, S_POP,
    S_AUG, S_DONE
  } state_t;

  state_t state;
  logic [CW-1:0] left_count, right_count;
  logic [CW-1:0] lc, rc;
  logic [LW-1:0] clr_idx;
  logic [RW-1:0] init_idx;
  logic [LW:0]   u;
  logic [CW-1:0] total;
  logic [CW-1:0] count_out;
  logic [LW:0]   depth;
  logic [RowW-1:0] visited;
  logic [LW-1:0] cur_x;
  logic [RW:0]   cur_r;
  logic [LW-1:0] edge_l;
  logic [RW-1:0] edge_r;

  // adjacency ram
  logic            adj_we;
  logic [LW-1:0]   adj_waddr, adj_raddr;
  logic [RowW-1:0] adj_wdata, adj_rdata;
  // right partner: valid bit + left index
  logic          rp_we;
  logic [RW-1:0] rp_waddr, rp_raddr;
  logic [LW:0]   rp_wdata, rp_rdata;
  // stack: vertex, chosen
  logic          st_we;
  logic [LW-1:0] st_waddr, st_raddr;
  logic [LW+RW-1:0] st_wdata, st_rdata;

  bpm_ram #(.Width(RowW), .Depth(bpm_pkg::MaxLeft)) u_adj (
    .clk, .we(adj_we), .waddr(adj_waddr), .wdata(adj_wdata),
    .raddr(adj_raddr), .rdata(adj_rdata));
  bpm_ram #(.Width(LW+1), .Depth(bpm_pkg::MaxRight)) u_rp (
    .clk, .we(rp_we), .waddr(rp_waddr), .wdata(rp_wdata),
    .raddr(rp_raddr), .rdata(rp_rdata));
  bpm_ram #(.Width(LW+RW), .Depth(bpm_pkg::MaxLeft)) u_stk (
    .clk, .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata));

  assign lc = (left_count > CW'(bpm_pkg::MaxLeft)) ? CW'(bpm_pkg::MaxLeft)
                                                   : left_count;
  assign rc = (right_count > CW'(bpm_pkg::MaxRight)) ? CW'(bpm_pkg::MaxRight)
                                                     : right_count;

  logic in_mode;
  logic [5:0] in_l, in_r;
  assign in_mode = s_tdata[0];
  assign in_l = s_tdata[6:1];
  assign in_r = s_tdata[12:7];

  // result register frees the engine as soon as the old result leaves
  logic out_free;
  assign out_free = !m_tvalid || m_tready;

  assign s_tready = (state == S_IDLE);
  assign pready = 1'b1;
  assign m_tdata = {1'b0, count_out};

  always_comb begin
    prdata = '0;
    case (paddr[2])
      bpm_pkg::RegLeftCount: prdata = {25'b0, left_count};
      default: prdata = {25'b0, right_count};
    endcase
  end

  // edge write is a read-modify-write; the row is read on acceptance
  logic edge_ok;
  assign edge_ok = ({1'b0, in_l} < lc) && ({1'b0, in_r} < rc);

  // candidate edge at cur_r in the current row
  logic scan_end;
  logic cand;
  assign scan_end = (cur_r >= (RW+1)'(rc));
  assign cand = adj_rdata[cur_r[RW-1:0]] && !visited[cur_r[RW-1:0]];

  always_comb begin
    adj_we = 1'b0;
    adj_waddr = edge_l;
    adj_wdata = adj_rdata | (RowW'(1) << edge_r);
    adj_raddr = cur_x;
    rp_we = 1'b0;
    rp_waddr = cur_r[RW-1:0];
    rp_wdata = {1'b1, cur_x};
    rp_raddr = cur_r[RW-1:0];
    st_we = 1'b0;
    st_waddr = LW'(depth - 1'b1);
    st_wdata = {cur_x, cur_r[RW-1:0]};
    // parent frame, used on pop and during augment
    st_raddr = LW'(depth - 2'd2);
    case (state)
      S_CLEAR: begin
        adj_we = 1'b1;
        adj_waddr = clr_idx;
        adj_wdata = '0;
      end
      S_IDLE: adj_raddr = in_l[LW-1:0];
      S_EDGE: adj_we = 1'b1;
      S_INIT: begin
        rp_we = 1'b1;
        rp_waddr = init_idx;
        rp_wdata = '0;
      end
      S_SCAN: st_we = !scan_end && cand;
      S_CHECK: rp_we = !rp_rdata[LW];
      S_AUG: begin
        rp_we = 1'b1;
        rp_waddr = st_rdata[RW-1:0];
        rp_wdata = {1'b1, st_rdata[LW+RW-1:RW]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_idx <= '0;
      left_count <= '0;
      right_count <= '0;
      m_tvalid <= 1'b0;
      count_out <= '0;
    end else begin
      if (psel && penable && pwrite) begin
        case (paddr[2])
          bpm_pkg::RegLeftCount: left_count <= pwdata[CW-1:0];
          default: right_count <= pwdata[CW-1:0];
        endcase
      end
      if (state == S_DONE && out_free) begin
        m_tvalid <= 1'b1;
        count_out <= total;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == LW'(bpm_pkg::MaxLeft - 1)) state <= S_IDLE;
        end
        S_IDLE: if (s_tvalid && s_tready) begin
          if (!in_mode) begin
            edge_l <= in_l[LW-1:0];
            edge_r <= in_r[RW-1:0];
            if (edge_ok) state <= S_EDGE;
          end else begin
            init_idx <= '0;
            state <= S_INIT;
          end
        end
        S_EDGE: state <= S_IDLE;
        S_INIT: begin
          init_idx <= init_idx + 1'b1;
          if (init_idx == RW'(bpm_pkg::MaxRight - 1)) begin
            total <= '0;
            u <= '0;
            state <= S_NEXTU;
          end
        end
        S_NEXTU: begin
          if (u >= (LW+1)'(lc)) begin
            state <= S_DONE;
          end else begin
            visited <= '0;
            depth <= (LW+1)'(1);
            cur_x <= u[LW-1:0];
            cur_r <= '0;
            state <= S_FRAME;
          end
        end
        S_FRAME: state <= S_SCAN;  // row read in flight
        S_SCAN: begin
          if (scan_end) begin
            if (depth == (LW+1)'(1)) begin
              u <= u + 1'b1;
              state <= S_NEXTU;
            end else begin
              depth <= depth - 1'b1;
              state <= S_POP;  // parent frame read in flight
            end
          end else if (cand) begin
            visited[cur_r[RW-1:0]] <= 1'b1;
            state <= S_CHECK;
          end else begin
            cur_r <= cur_r + 1'b1;
          end
        end
        S_CHECK: begin
          // rp_rdata holds partner of cur_r
          if (!rp_rdata[LW]) begin
            if (depth == (LW+1)'(1)) begin
              total <= total + 1'b1;
              u <= u + 1'b1;
              state <= S_NEXTU;
            end else begin
              depth <= depth - 1'b1;
              state <= S_AUG;
            end
          end else if (depth < (LW+1)'(bpm_pkg::MaxLeft)) begin
            depth <= depth + 1'b1;
            cur_x <= rp_rdata[LW-1:0];
            cur_r <= '0;
            state <= S_FRAME;
          end else begin
            cur_r <= cur_r + 1'b1;
            state <= S_SCAN;
          end
        end
        S_POP: begin
          // resume the parent just past its chosen vertex
          cur_x <= st_rdata[LW+RW-1:RW];
          cur_r <= (RW+1)'(st_rdata[RW-1:0]) + 1'b1;
          state <= S_FRAME;
        end
        S_AUG: begin
          // st_rdata holds frame depth-1, written to the partner ram here
          if (depth == (LW+1)'(1)) begin
            total <= total + 1'b1;
            u <= u + 1'b1;
            state <= S_NEXTU;
          end else begin
            depth <= depth - 1'b1;
          end
        end
        S_DONE: if (out_free) begin
          clr_idx <= '0;
          state <= S_CLEAR;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/core/bpm_checker.sv =====
// ----------------------------------------------------------------------------
// bpm_checker
// port-level checks for the bipartite matching block
// ----------------------------------------------------------------------------
module bpm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [15:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic        pready
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata <= 8'd64) else $error("count out of range");
  a_finish: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tdata[0] |=> !s_tready) else $error("input taken during search");
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid) else $error("result valid after reset");
  a_rdy: assert property (@(posedge clk) pready) else $error("pready low");
endmodule

bind bipartite_max_matching bpm_checker u_bpm_checker (
  .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata, .pready);

// ===== sim/tb_bipartite_max_matching.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bipartite_max_matching
// drives edge and finish transactions into the matching block, predicts each
// maximum matching size with an augmenting-path search, and compares results
// ----------------------------------------------------------------------------
module tb_bipartite_max_matching;
  localparam int   MaxLeft  = bpm_pkg::MaxLeft;
  localparam int   MaxRight = bpm_pkg::MaxRight;
  localparam logic ModeEdge   = 1'b0;
  localparam logic ModeFinish = 1'b1;
  localparam int   SettleCycles = 400;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // mode[0], left_vertex[6:1], right_vertex[12:7]
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // match_count[6:0]
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bipartite_max_matching dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state
  logic [MaxRight-1:0] graph_rows [MaxLeft];
  logic [6:0] cfg_left;
  logic [6:0] cfg_right;
  logic [6:0] size_queue [$];
  int  fail_count;
  int  burst_left;
  int  stall_mode;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int eff(input logic [6:0] v, input int lim);
    return (v > lim) ? lim : int'(v);
  endfunction

  function automatic int max_matching_size();
    int lc, rc, total, depth, x, r;
    int owner [MaxRight];
    int stk_v [MaxLeft];
    int stk_n [MaxLeft];
    int stk_c [MaxLeft];
    bit seen [MaxRight];
    bit down, found;
    lc = eff(cfg_left, MaxLeft);
    rc = eff(cfg_right, MaxRight);
    total = 0;
    for (int i = 0; i < MaxRight; i++) owner[i] = -1;
    for (int u = 0; u < lc; u++) begin
      for (int i = 0; i < MaxRight; i++) seen[i] = 1'b0;
      depth = 1; stk_v[0] = u; stk_n[0] = 0; stk_c[0] = 0; found = 1'b0;
      while (depth > 0 && !found) begin
        x = stk_v[depth-1];
        r = stk_n[depth-1];
        down = 1'b0;
        while (r < rc && !down && !found) begin
          if (graph_rows[x][r] && !seen[r]) begin
            seen[r] = 1'b1;
            stk_n[depth-1] = r + 1;
            stk_c[depth-1] = r;
            if (owner[r] < 0) begin
              for (int k = depth; k > 0; k--) owner[stk_c[k-1]] = stk_v[k-1];
              found = 1'b1;
            end else if (depth < MaxLeft) begin
              stk_v[depth] = owner[r]; stk_n[depth] = 0; stk_c[depth] = 0;
              depth++;
              down = 1'b1;
            end
          end
          if (!down && !found) r++;
        end
        if (!down && !found) depth--;
      end
      // left vertices are tried once, so a matched start is never revisited
      if (found) total++;
    end
    return total;
  endfunction

  task automatic apb_write(input logic idx, input logic [6:0] val);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= {25'd0, val};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == bpm_pkg::RegLeftCount) cfg_left = val; else cfg_right = val;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (size_queue.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_counts(input logic [6:0] lc, input logic [6:0] rc);
    wait_drained();
    apb_write(bpm_pkg::RegLeftCount, lc);
    apb_write(bpm_pkg::RegRightCount, rc);
  endtask

  // one item; bursts with random gaps between them
  task automatic send_item(input logic mode, input logic [5:0] lv,
                           input logic [5:0] rv);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {3'd0, rv, lv, mode};
    do @(posedge clk); while (!s_tready);
    if (mode == ModeFinish) begin
      size_queue.push_back(7'(max_matching_size()));
      for (int i = 0; i < MaxLeft; i++) graph_rows[i] = '0;
    end else if (lv < eff(cfg_left, MaxLeft) && rv < eff(cfg_right, MaxRight)) begin
      graph_rows[lv][rv] = 1'b1;
    end
  endtask

  task automatic test_directed();
    set_counts(7'd0, 7'd0);
    send_item(ModeEdge, 6'd0, 6'd0);
    send_item(ModeFinish, 6'd0, 6'd0);
    set_counts(7'd4, 7'd4);
    send_item(ModeFinish, 6'd63, 6'd63);
    send_item(ModeEdge, 6'd0, 6'd0);
    send_item(ModeEdge, 6'd0, 6'd0);
    send_item(ModeEdge, 6'd0, 6'd1);
    send_item(ModeEdge, 6'd1, 6'd0);
    send_item(ModeEdge, 6'd2, 6'd1);
    send_item(ModeEdge, 6'd3, 6'd9);
    send_item(ModeEdge, 6'd63, 6'd2);
    send_item(ModeFinish, 6'd0, 6'd0);
    set_counts(7'd127, 7'd127);
    send_item(ModeEdge, 6'd63, 6'd63);
    send_item(ModeEdge, 6'd63, 6'd0);
    send_item(ModeEdge, 6'd0, 6'd63);
    send_item(ModeEdge, 6'd10, 6'd20);
    // edges stored, then counts shrink before the finish
    set_counts(7'd64, 7'd30);
    send_item(ModeFinish, 6'd0, 6'd0);
    set_counts(7'd65, 7'd64);
    send_item(ModeEdge, 6'd42, 6'd21);
    send_item(ModeFinish, 6'd0, 6'd0);
  endtask

  task automatic test_random_graphs();
    int lc, rc, n, dens;
    int sent;
    sent = 0;
    while (sent < 540) begin
      case ($urandom_range(0, 5))
        0: begin lc = 64; rc = 64; end
        1: begin lc = $urandom_range(0, 127); rc = $urandom_range(0, 127); end
        default: begin lc = $urandom_range(1, 12); rc = $urandom_range(1, 12); end
      endcase
      set_counts(7'(lc), 7'(rc));
      n = $urandom_range(0, 30);
      dens = $urandom_range(0, 9);
      for (int i = 0; i < n; i++) begin
        if (dens != 0 && lc > 0 && rc > 0)
          send_item(ModeEdge, 6'($urandom_range(0, eff(7'(lc), 64) - 1)),
                    6'($urandom_range(0, eff(7'(rc), 64) - 1)));
        else
          send_item(ModeEdge, 6'($urandom), 6'($urandom));
      end
      send_item(ModeFinish, 6'($urandom), 6'($urandom));
      sent += n + 1;
    end
  endtask

  // receiver stall pattern
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if ($urandom_range(0, 31) == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 3) != 0);
        default: m_tready <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (size_queue.size() == 0) begin
        $error("match_count: unexpected transaction, actual %0d", m_tdata[6:0]);
        fail_count++;
      end else begin
        if (m_tdata[6:0] !== size_queue[0]) begin
          $error("match_count: expected %0d, actual %0d", size_queue[0], m_tdata[6:0]);
          fail_count++;
        end
        void'(size_queue.pop_front());
      end
    end
  end

  initial begin
    rst = 1'b1; s_tvalid = 1'b0; s_tdata = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    stall_mode = 0;
    fail_count = 0; burst_left = 0; cfg_left = '0; cfg_right = '0;
    for (int i = 0; i < MaxLeft; i++) graph_rows[i] = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random_graphs();
    wait_drained();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
